[sv/latched_fault_alarm_controller_macros.svh]
// Assertion macros for the latched fault alarm controller.
// Used by the top level only; needs nothing else.
`ifndef LATCHED_FAULT_ALARM_CONTROLLER_MACROS_SVH
`define LATCHED_FAULT_ALARM_CONTROLLER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LFAC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LFAC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/lfac_pkg.sv]
// Shared types and constants of the latched fault alarm controller.
// No dependencies.
package lfac_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE     = 2'd0,
        MODE_SAFE     = 2'd1,
        MODE_ERR_TEMP = 2'd2,
        MODE_ERR_VOLT = 2'd3
    } mode_t;

    localparam logic [1:0] EVT_NONE    = 2'd0;
    localparam logic [1:0] EVT_ACCEPT  = 2'd1;
    localparam logic [1:0] EVT_REFUSED = 2'd2;

    localparam logic [2:0] CFG_TEMP_LIMIT   = 3'd0;
    localparam logic [2:0] CFG_VOLT_LIMIT   = 3'd1;
    localparam logic [2:0] CFG_LONG_PRESS   = 3'd2;
    localparam logic [2:0] CFG_TEMP_BLINK   = 3'd3;
    localparam logic [2:0] CFG_TEMP_BUZZ    = 3'd4;
    localparam logic [2:0] CFG_VOLT_BLINK   = 3'd5;
    localparam logic [2:0] CFG_VOLT_BUZZ    = 3'd6;
    localparam logic [2:0] CFG_LED_DUTY     = 3'd7;

    localparam logic [10:0] REF_MV = 11'd1200;

    typedef struct packed {
        logic [7:0]  temp_limit;
        logic [11:0] volt_limit_mv;
        logic [15:0] key2_hold_ms;
        logic [15:0] temp_blink_half_ms;
        logic [15:0] temp_buzz_half_ms;
        logic [15:0] volt_blink_half_ms;
        logic [15:0] volt_buzz_half_ms;
        logic [6:0]  led_full_duty;
    } cfg_t;

    typedef struct packed {
        logic [31:0] time_ms;
        logic        key1_down;
        logic        key2_down;
        logic        temp_valid;
        logic [7:0]  temp_reading;
        logic [11:0] ref_code;
        logic [11:0] chan_a_code;
        logic [11:0] chan_b_code;
    } item_t;

    typedef struct packed {
        mode_t      mode;
        logic       latched;
        logic       running;
        logic [6:0] red_duty;
        logic [6:0] green_duty;
        logic [6:0] blue_duty;
        logic       buzzer_on;
        logic       buzzer_tone;
        logic [1:0] reset_event;
    } res_t;

endpackage

[sv/lfac_uv_check.sv]
// Undervoltage compare for one ADC channel: code*1200 < limit*ref.
// Depends on lfac_pkg.
module lfac_uv_check
(
    input  logic [11:0] code,
    input  logic [11:0] ref_code,
    input  logic [11:0] limit_mv,
    output logic        low
);

    logic [23:0] code_prod;
    logic [23:0] limit_prod;

    assign code_prod  = code * {1'b0, lfac_pkg::REF_MV};
    assign limit_prod = limit_mv * ref_code;

    // a zero reference code never reports undervoltage
    assign low = (ref_code != 12'd0) && (code_prod < limit_prod);

endmodule

[sv/lfac_core.sv]
// Monitor state and the one-pass update for each word: keys, fault latch,
// mode selection, blink and buzzer timing. Depends on lfac_pkg, lfac_uv_check.
module lfac_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  lfac_pkg::item_t   item,
    input  lfac_pkg::cfg_t    cfg,
    output lfac_pkg::res_t    res
);

    logic                run_reg, run_next;
    logic                start_held_reg, start_held_next;
    logic                latch_reg, latch_next;
    logic                hold_reg, hold_next;
    lfac_pkg::mode_t     mode_reg, mode_next;
    logic [31:0]         hold_start_reg, hold_start_next;
    logic [31:0]         blink_mark_reg, blink_mark_next;
    logic [31:0]         buzz_mark_reg, buzz_mark_next;
    logic                blink_phase_reg, blink_phase_next;
    logic                buzz_phase_reg, buzz_phase_next;
    logic [7:0]          temp_reg, temp_next;
    logic                a_low_reg, a_low_next;
    logic                b_low_reg, b_low_next;
    logic [6:0]          red_reg, red_next;
    logic [6:0]          green_reg, green_next;
    logic [6:0]          blue_reg, blue_next;
    logic                buzz_on_reg, buzz_on_next;
    logic                tone_reg, tone_next;
    logic [1:0]          evt;

    logic                a_low_now;
    logic                b_low_now;
    logic [15:0]         blink_half;
    logic [15:0]         buzz_half;
    logic                alarm_blue;

    lfac_uv_check u_uv_a
    (
        .code     (item.chan_a_code),
        .ref_code (item.ref_code),
        .limit_mv (cfg.volt_limit_mv),
        .low      (a_low_now)
    );

    lfac_uv_check u_uv_b
    (
        .code     (item.chan_b_code),
        .ref_code (item.ref_code),
        .limit_mv (cfg.volt_limit_mv),
        .low      (b_low_now)
    );

    always_comb
    begin
        run_next         = run_reg;
        start_held_next  = start_held_reg;
        latch_next       = latch_reg;
        hold_next        = hold_reg;
        mode_next        = mode_reg;
        hold_start_next  = hold_start_reg;
        blink_mark_next  = blink_mark_reg;
        buzz_mark_next   = buzz_mark_reg;
        blink_phase_next = blink_phase_reg;
        buzz_phase_next  = buzz_phase_reg;
        temp_next        = temp_reg;
        a_low_next       = a_low_reg;
        b_low_next       = b_low_reg;
        red_next         = red_reg;
        green_next       = green_reg;
        blue_next        = blue_reg;
        buzz_on_next     = buzz_on_reg;
        tone_next        = tone_reg;
        evt              = lfac_pkg::EVT_NONE;
        blink_half       = cfg.temp_blink_half_ms;
        buzz_half        = cfg.temp_buzz_half_ms;
        alarm_blue       = 1'b0;

        // start key: act on the press edge only
        if (item.key1_down)
        begin
            if (!start_held_reg)
            begin
                start_held_next = 1'b1;
                run_next        = 1'b1;
                mode_next       = lfac_pkg::MODE_SAFE;
            end
        end
        else
        begin
            start_held_next = 1'b0;
        end

        // reset key: long hold attempts to clear the latch on old readings
        if (item.key2_down)
        begin
            if (!hold_reg)
            begin
                hold_next       = 1'b1;
                hold_start_next = item.time_ms;
            end
            else if ((item.time_ms - hold_start_reg) > {16'd0, cfg.key2_hold_ms})
            begin
                if ((temp_reg <= cfg.temp_limit) && !a_low_reg && !b_low_reg)
                begin
                    latch_next   = 1'b0;
                    mode_next    = lfac_pkg::MODE_SAFE;
                    red_next     = 7'd0;
                    green_next   = 7'd0;
                    blue_next    = 7'd0;
                    buzz_on_next = 1'b0;
                    evt          = lfac_pkg::EVT_ACCEPT;
                end
                else
                begin
                    evt = lfac_pkg::EVT_REFUSED;
                end
                hold_next       = 1'b0;
                hold_start_next = 32'd0;
            end
        end
        else
        begin
            hold_next       = 1'b0;
            hold_start_next = 32'd0;
        end

        if (run_next)
        begin
            if (item.temp_valid)
            begin
                temp_next = item.temp_reading;
            end
            a_low_next = a_low_now;
            b_low_next = b_low_now;

            if (!latch_next)
            begin
                if (temp_next > cfg.temp_limit)
                begin
                    mode_next  = lfac_pkg::MODE_ERR_TEMP;
                    latch_next = 1'b1;
                end
                else if (a_low_next || b_low_next)
                begin
                    mode_next  = lfac_pkg::MODE_ERR_VOLT;
                    latch_next = 1'b1;
                end
                else
                begin
                    mode_next = lfac_pkg::MODE_SAFE;
                end
            end

            if (mode_next == lfac_pkg::MODE_ERR_VOLT)
            begin
                blink_half = cfg.volt_blink_half_ms;
                buzz_half  = cfg.volt_buzz_half_ms;
                alarm_blue = 1'b1;
            end

            case (mode_next)
                lfac_pkg::MODE_SAFE:
                begin
                    red_next     = 7'd0;
                    green_next   = cfg.led_full_duty;
                    blue_next    = 7'd0;
                    buzz_on_next = 1'b0;
                end
                lfac_pkg::MODE_ERR_TEMP, lfac_pkg::MODE_ERR_VOLT:
                begin
                    if ((item.time_ms - blink_mark_reg) >= {16'd0, blink_half})
                    begin
                        blink_mark_next  = item.time_ms;
                        blink_phase_next = !blink_phase_reg;
                    end
                    red_next   = (blink_phase_next && !alarm_blue) ? cfg.led_full_duty : 7'd0;
                    green_next = 7'd0;
                    blue_next  = (blink_phase_next && alarm_blue) ? cfg.led_full_duty : 7'd0;

                    if ((item.time_ms - buzz_mark_reg) >= {16'd0, buzz_half})
                    begin
                        buzz_mark_next  = item.time_ms;
                        buzz_phase_next = !buzz_phase_reg;
                    end
                    buzz_on_next = buzz_phase_next;
                    // tone keeps its last value while the buzzer is off
                    if (buzz_phase_next)
                    begin
                        tone_next = alarm_blue;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg         <= 1'b0;
            start_held_reg  <= 1'b0;
            latch_reg       <= 1'b0;
            hold_reg        <= 1'b0;
            mode_reg        <= lfac_pkg::MODE_IDLE;
            hold_start_reg  <= 32'd0;
            blink_mark_reg  <= 32'd0;
            buzz_mark_reg   <= 32'd0;
            blink_phase_reg <= 1'b0;
            buzz_phase_reg  <= 1'b0;
            temp_reg        <= 8'd0;
            a_low_reg       <= 1'b1;
            b_low_reg       <= 1'b1;
            red_reg         <= 7'd0;
            green_reg       <= 7'd0;
            blue_reg        <= 7'd0;
            buzz_on_reg     <= 1'b0;
            tone_reg        <= 1'b0;
        end
        else if (step)
        begin
            run_reg         <= run_next;
            start_held_reg  <= start_held_next;
            latch_reg       <= latch_next;
            hold_reg        <= hold_next;
            mode_reg        <= mode_next;
            hold_start_reg  <= hold_start_next;
            blink_mark_reg  <= blink_mark_next;
            buzz_mark_reg   <= buzz_mark_next;
            blink_phase_reg <= blink_phase_next;
            buzz_phase_reg  <= buzz_phase_next;
            temp_reg        <= temp_next;
            a_low_reg       <= a_low_next;
            b_low_reg       <= b_low_next;
            red_reg         <= red_next;
            green_reg       <= green_next;
            blue_reg        <= blue_next;
            buzz_on_reg     <= buzz_on_next;
            tone_reg        <= tone_next;
        end
    end

    always_comb
    begin
        res.mode        = mode_next;
        res.latched     = latch_next;
        res.running     = run_next;
        res.red_duty    = red_next;
        res.green_duty  = green_next;
        res.blue_duty   = blue_next;
        res.buzzer_on   = buzz_on_next;
        res.buzzer_tone = tone_next;
        res.reset_event = evt;
    end

endmodule

[sv/latched_fault_alarm_controller.sv]
// Top level of the latched fault alarm controller: input word register,
// configuration registers, result register. Depends on lfac_pkg, lfac_core.
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+------------------------------------------
//  input    | in_valid / in_ready  | time_ms, keys, temperature, ADC codes
//  result   | out_valid / out_ready| mode, latched, running, duties, buzzer, event
//  config   | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One word per cycle sustained while the result side does not stall; an accepted word
// goes from the input register through one pass of lfac_core into the result register.
// Both registers hold while the result side stalls; in_ready drops only when both are full.
// cfg_ready is always high. Reset acts at once on all state but the two word registers.
`include "latched_fault_alarm_controller_macros.svh"

module latched_fault_alarm_controller
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] time_ms,
    input  logic        key1_down,
    input  logic        key2_down,
    input  logic        temp_valid,
    input  logic [7:0]  temp_reading,
    input  logic [11:0] ref_code,
    input  logic [11:0] chan_a_code,
    input  logic [11:0] chan_b_code,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  mode,
    output logic        latched,
    output logic        running,
    output logic [6:0]  red_duty,
    output logic [6:0]  green_duty,
    output logic [6:0]  blue_duty,
    output logic        buzzer_on,
    output logic        buzzer_tone,
    output logic [1:0]  reset_event,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    lfac_pkg::cfg_t   cfg_reg;
    lfac_pkg::item_t  item_reg;
    lfac_pkg::res_t   res_reg;
    lfac_pkg::res_t   res_next;
    logic             in_valid_reg;
    logic             out_valid_reg;
    logic             advance;
    logic             step;

    assign cfg_ready = 1'b1;
    assign advance   = !out_valid_reg || out_ready;
    assign step      = in_valid_reg && advance;
    assign in_ready  = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.temp_limit         <= 8'd28;
            cfg_reg.volt_limit_mv      <= 12'd2000;
            cfg_reg.key2_hold_ms       <= 16'd1500;
            cfg_reg.temp_blink_half_ms <= 16'd500;
            cfg_reg.temp_buzz_half_ms  <= 16'd500;
            cfg_reg.volt_blink_half_ms <= 16'd250;
            cfg_reg.volt_buzz_half_ms  <= 16'd200;
            cfg_reg.led_full_duty      <= 7'd99;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                lfac_pkg::CFG_TEMP_LIMIT: cfg_reg.temp_limit         <= cfg_data[7:0];
                lfac_pkg::CFG_VOLT_LIMIT: cfg_reg.volt_limit_mv      <= cfg_data[11:0];
                lfac_pkg::CFG_LONG_PRESS: cfg_reg.key2_hold_ms       <= cfg_data;
                lfac_pkg::CFG_TEMP_BLINK: cfg_reg.temp_blink_half_ms <= cfg_data;
                lfac_pkg::CFG_TEMP_BUZZ:  cfg_reg.temp_buzz_half_ms  <= cfg_data;
                lfac_pkg::CFG_VOLT_BLINK: cfg_reg.volt_blink_half_ms <= cfg_data;
                lfac_pkg::CFG_VOLT_BUZZ:  cfg_reg.volt_buzz_half_ms  <= cfg_data;
                lfac_pkg::CFG_LED_DUTY:   cfg_reg.led_full_duty      <= cfg_data[6:0];
                default:
                begin
                end
            endcase
        end
    end

    // input word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.time_ms      <= time_ms;
            item_reg.key1_down    <= key1_down;
            item_reg.key2_down    <= key2_down;
            item_reg.temp_valid   <= temp_valid;
            item_reg.temp_reading <= temp_reading;
            item_reg.ref_code     <= ref_code;
            item_reg.chan_a_code  <= chan_a_code;
            item_reg.chan_b_code  <= chan_b_code;
        end
    end

    lfac_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (item_reg),
        .cfg   (cfg_reg),
        .res   (res_next)
    );

    // result word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign mode        = res_reg.mode;
    assign latched     = res_reg.latched;
    assign running     = res_reg.running;
    assign red_duty    = res_reg.red_duty;
    assign green_duty  = res_reg.green_duty;
    assign blue_duty   = res_reg.blue_duty;
    assign buzzer_on   = res_reg.buzzer_on;
    assign buzzer_tone = res_reg.buzzer_tone;
    assign reset_event = res_reg.reset_event;

    `LFAC_ASSERT_IMPLIES(a_stall_only_when_full, clk, rst_n, !in_ready,
        in_valid_reg && out_valid_reg && !out_ready, "input stalled without a full pipeline")
    `LFAC_ASSERT_IMPLIES(a_latch_not_idle, clk, rst_n, out_valid && latched,
        mode != lfac_pkg::MODE_IDLE, "latched fault reported in idle mode")
    // while running, the same pass may latch a fresh fault after the clear
    `LFAC_ASSERT_IMPLIES(a_accept_clears, clk, rst_n,
        out_valid && !running && (reset_event == lfac_pkg::EVT_ACCEPT),
        !latched && (mode == lfac_pkg::MODE_SAFE), "accepted reset left latch or wrong mode")
    `LFAC_ASSERT_NEXT(a_result_held, clk, rst_n,
        out_valid && !out_ready && !$isunknown(res_reg), $stable(res_reg),
        "stalled result word changed")

endmodule
